/* hw/rtl/wns_pkg.sv */
// ============================================================================
// wns_pkg
// Shared types, codes and constants of the wavetable note sequencer.
// ============================================================================
package wns_pkg;

  // Default table depths.
  localparam int DEF_WAVE_DEPTH = 64;
  localparam int DEF_NOTE_DEPTH = 256;

  // Field widths.
  localparam int ACTION_W  = 2;
  localparam int INDEX_W   = 8;
  localparam int SAMPLE_W  = 12;
  localparam int LENGTH_W  = 16;
  localparam int PITCH_W   = 20;
  localparam int PERIOD_W  = 24;
  localparam int WLEN_W    = 7;
  localparam int SLEN_W    = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam int COUNT_W   = 34;
  localparam int QUOT_W    = 11;
  localparam int DW_W      = LENGTH_W + WLEN_W;

  // Pitch divide by 1000 as a multiply by a rounded-up reciprocal.
  // The error term stays below one for every 20-bit pitch.
  localparam int PITCH_SHIFT = 30;
  localparam int RECIP_W     = 21;
  localparam int PROD_W      = PITCH_W + RECIP_W;
  localparam logic [RECIP_W-1:0] PITCH_RECIP = RECIP_W'(1073742);

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_WAVE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOAD_NOTE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_START     = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SONG_LENGTH = 1'd1;

  // One entry of the note table.
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PITCH_W-1:0]  pitch;
    logic [LENGTH_W-1:0] duration;
  } note_entry_t;

  localparam int NOTE_ENTRY_W = $bits(note_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_wave;
    logic load_note;
    logic start;
    logic read_step;
    logic mul_step;
    logic cmp_step;
    logic period_step;
    logic out_load;
  } wns_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } wns_status_t;

  // Truncating divide of a pitch by 1000.
  function automatic logic [QUOT_W-1:0] pitch_div1000(input logic [PITCH_W-1:0] pitch);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(pitch) * PROD_W'(PITCH_RECIP);
    return prod[PROD_W-1:PITCH_SHIFT];
  endfunction

endpackage

/* hw/rtl/wns_ram.sv */
// ============================================================================
// wns_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module wns_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/wns_ctrl.sv */
// ============================================================================
// wns_ctrl
// Sequencing state machine: accepts items and steps the datapath through
// the load, start and tick operations.
// ============================================================================
module wns_ctrl
  import wns_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] action,
  input  wns_status_t         status,
  output wns_cmd_t            cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_RDP  = 3'd4;
  localparam logic [2:0] S_PER  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_TICK: begin
              state_next = S_READ;
            end
            ACT_LOAD_WAVE: begin
              cmd.load_wave = 1'b1;
            end
            ACT_LOAD_NOTE: begin
              cmd.load_note = 1'b1;
            end
            ACT_START: begin
              cmd.start  = 1'b1;
              state_next = S_RDP;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd.read_step = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_next   = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        state_next   = S_RDP;
      end
      S_RDP: begin
        state_next = S_PER;
      end
      S_PER: begin
        cmd.period_step = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/wns_dp.sv */
// ============================================================================
// wns_dp
// Datapath: wave and note tables, play positions, tick counter, note limit
// arithmetic and the output register.
// ============================================================================
module wns_dp
  import wns_pkg::*;
#(
  parameter int WAVE_DEPTH = DEF_WAVE_DEPTH,
  parameter int NOTE_DEPTH = DEF_NOTE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wns_cmd_t              cmd,
  output wns_status_t           status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [INDEX_W-1:0]    entry_index,
  input  logic [SAMPLE_W-1:0]   sample_value,
  input  logic [LENGTH_W-1:0]   note_length,
  input  logic [PITCH_W-1:0]    note_pitch,
  input  logic [PERIOD_W-1:0]   note_period,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   dac_value,
  output logic                  led_level,
  output logic                  reload_valid,
  output logic [PERIOD_W-1:0]   timer_reload,
  output logic [INDEX_W-1:0]    current_note
);

  localparam int WP_W = $clog2(WAVE_DEPTH);
  localparam int NP_W = $clog2(NOTE_DEPTH);
  localparam int WCAP = (WAVE_DEPTH < 127) ? WAVE_DEPTH : 127;
  localparam int SCAP = (NOTE_DEPTH < 511) ? NOTE_DEPTH : 511;

  // Configuration registers.
  logic [WLEN_W-1:0] wave_length;
  logic [SLEN_W-1:0] song_length;
  logic [WLEN_W-1:0] wlen;
  logic [SLEN_W-1:0] slen;

  // Play state.
  logic [WP_W-1:0]    wave_position;
  logic [NP_W-1:0]    note_position;
  logic [COUNT_W-1:0] tick_count;
  logic               led_state;
  logic [WP_W-1:0]    wave_position_next;
  logic [NP_W-1:0]    note_position_next;

  // Work registers of one tick.
  logic [SAMPLE_W-1:0] dac_r;
  logic [QUOT_W-1:0]   quot_r;
  logic [DW_W-1:0]     dw_r;
  logic [COUNT_W-1:0]  limit_r;
  logic                hit_r;
  logic [PERIOD_W-1:0] reload_r;

  // Table ports.
  logic                wave_we;
  logic                note_we;
  logic [SAMPLE_W-1:0] wave_q;
  note_entry_t         note_wdata;
  note_entry_t         note_q;
  logic [NOTE_ENTRY_W-1:0] note_q_raw;

  // Lengths clamped to the range one to the table depth, at most 127 for the wave and 511 for the song.
  always_comb begin
    if (wave_length == '0) begin
      wlen = WLEN_W'(1);
    end else if (32'(wave_length) > 32'(WCAP)) begin
      wlen = WLEN_W'(WCAP);
    end else begin
      wlen = wave_length;
    end
    if (song_length == '0) begin
      slen = SLEN_W'(1);
    end else if (32'(song_length) > 32'(SCAP)) begin
      slen = SLEN_W'(SCAP);
    end else begin
      slen = song_length;
    end
  end

  // Wrapping advance of both play positions.
  assign wave_position_next = (16'(wave_position) + 16'd1 >= 16'(wlen)) ? '0 :
                              wave_position + WP_W'(1);
  assign note_position_next = (16'(note_position) + 16'd1 >= 16'(slen)) ? '0 :
                              note_position + NP_W'(1);

  // Loads beyond a table's depth are dropped.
  assign wave_we = cmd.load_wave && (32'(entry_index) < 32'(WAVE_DEPTH));
  assign note_we = cmd.load_note && (32'(entry_index) < 32'(NOTE_DEPTH));

  assign note_wdata.period   = note_period;
  assign note_wdata.pitch    = note_pitch;
  assign note_wdata.duration = note_length;

  wns_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WAVE_DEPTH)
  ) u_wave_ram (
    .clk   (clk),
    .we    (wave_we),
    .waddr (WP_W'(entry_index)),
    .wdata (sample_value),
    .raddr (wave_position),
    .rdata (wave_q)
  );

  wns_ram #(
    .WIDTH (NOTE_ENTRY_W),
    .DEPTH (NOTE_DEPTH)
  ) u_note_ram (
    .clk   (clk),
    .we    (note_we),
    .waddr (NP_W'(entry_index)),
    .wdata (note_wdata),
    .raddr (note_position),
    .rdata (note_q_raw)
  );

  assign note_q = note_entry_t'(note_q_raw);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_length <= WLEN_W'(32);
      song_length <= SLEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WAVE_LENGTH: wave_length <= cfg_data[WLEN_W-1:0];
        REG_SONG_LENGTH: song_length <= cfg_data[SLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Play positions, tick counter and indicator.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_position <= '0;
      note_position <= '0;
      tick_count    <= '0;
      led_state     <= 1'b0;
    end else if (cmd.start) begin
      wave_position <= '0;
      note_position <= '0;
      tick_count    <= '0;
    end else if (cmd.read_step) begin
      wave_position <= wave_position_next;
      if (tick_count != '1) begin
        tick_count <= tick_count + COUNT_W'(1);
      end
    end else if (cmd.cmp_step && (tick_count > limit_r)) begin
      led_state     <= ~led_state;
      tick_count    <= '0;
      note_position <= note_position_next;
    end
  end

  // Note limit arithmetic and result assembly.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dac_r <= '0;
      hit_r <= 1'b1;
    end
    if (cmd.read_step) begin
      dac_r  <= wave_q;
      quot_r <= pitch_div1000(note_q.pitch);
      dw_r   <= DW_W'(note_q.duration) * DW_W'(wlen);
    end
    if (cmd.mul_step) begin
      limit_r <= COUNT_W'(dw_r) * COUNT_W'(quot_r);
    end
    if (cmd.cmp_step) begin
      hit_r <= (tick_count > limit_r);
    end
    if (cmd.period_step) begin
      reload_r <= hit_r ? note_q.period : '0;
    end
  end

  // Output register.
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      dac_value    <= dac_r;
      led_level    <= led_state;
      reload_valid <= hit_r;
      timer_reload <= reload_r;
      current_note <= INDEX_W'(note_position);
    end
  end

endmodule

/* hw/rtl/wavetable_note_sequencer.sv */
// ============================================================================
// wavetable_note_sequencer
// Tick-driven wavetable tone player with a note table and timer reloads.
// ============================================================================
//
//  Channel   Direction  Handshake            Payload
//  input     in         in_valid/in_ready    action, entry_index, sample_value,
//                                            note_length, note_pitch, note_period
//  output    out        out_valid/out_ready  dac_value, led_level, reload_valid,
//                                            timer_reload, current_note
//  config    in         cfg_we               cfg_index, cfg_data
//
//  A load item gives no result. A start item runs period read and capture,
//  then the output register load; a tick item runs table read, divide and
//  scale, limit multiply and compare before those steps.
//  The datapath runs one item at a time; the next item is taken while the last
//  result still waits in the output register, and a full output register
//  stalls only the final load step of the next result.
//  Reset clears positions, counter and indicator and restores the default
//  lengths; tables are unset.
//
module wavetable_note_sequencer
  import wns_pkg::*;
#(
  parameter int WAVE_DEPTH = DEF_WAVE_DEPTH,
  parameter int NOTE_DEPTH = DEF_NOTE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACTION_W-1:0]  action,
  input  logic [INDEX_W-1:0]   entry_index,
  input  logic [SAMPLE_W-1:0]  sample_value,
  input  logic [LENGTH_W-1:0]  note_length,
  input  logic [PITCH_W-1:0]   note_pitch,
  input  logic [PERIOD_W-1:0]  note_period,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  dac_value,
  output logic                 led_level,
  output logic                 reload_valid,
  output logic [PERIOD_W-1:0]  timer_reload,
  output logic [INDEX_W-1:0]   current_note
);

  wns_cmd_t    cmd;
  wns_status_t status;

  wns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .status   (status),
    .cmd      (cmd)
  );

  wns_dp #(
    .WAVE_DEPTH (WAVE_DEPTH),
    .NOTE_DEPTH (NOTE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .entry_index  (entry_index),
    .sample_value (sample_value),
    .note_length  (note_length),
    .note_pitch   (note_pitch),
    .note_period  (note_period),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dac_value    (dac_value),
    .led_level    (led_level),
    .reload_valid (reload_valid),
    .timer_reload (timer_reload),
    .current_note (current_note)
  );

  // A load item never produces a result.
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACT_LOAD_WAVE || action == ACT_LOAD_NOTE))
    |=> !$rose(out_valid))
    else $error("result appeared after a load item");

  // A result without a note change carries no reload period.
  a_no_reload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reload_valid) |-> (timer_reload == '0))
    else $error("timer_reload nonzero without reload_valid");

  // The controller only loads the output register when it is free.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten while full");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule
